// ===== sv/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CHK_IMPLY(name, a, c, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CHK_NEXT(name, a, c, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== sv/mcete_pkg.sv =====
// types, codes and constants of the tween engine
package mcete_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_CANCEL_ID  = 3'd1;
    localparam logic [2:0] OP_CANCEL_ALL = 3'd2;
    localparam logic [2:0] OP_SNAP       = 3'd3;
    localparam logic [2:0] OP_TICK       = 3'd4;

    localparam logic [2:0] CURVE_LINEAR     = 3'd0;
    localparam logic [2:0] CURVE_OUT_QUAD   = 3'd1;
    localparam logic [2:0] CURVE_INOUT_QUAD = 3'd2;
    localparam logic [2:0] CURVE_OUT_CUBIC  = 3'd3;
    localparam logic [2:0] CURVE_IN_CUBIC   = 3'd4;
    localparam logic [2:0] CURVE_INOUT_CUBIC = 3'd5;

    localparam logic [1:0] MODE_SCALED   = 2'd0;
    localparam logic [1:0] MODE_UNSCALED = 2'd1;

    localparam logic [1:0] CFG_MOTION  = 2'd0;
    localparam logic [1:0] CFG_SPEED   = 2'd1;
    localparam logic [1:0] CFG_REDUCED = 2'd2;

    localparam logic [15:0] SPEED_RESET = 16'd256;
    localparam logic [31:0] SNAP_US     = 32'd1000;
    localparam logic [15:0] ID_FIRST    = 16'd1;
    localparam logic [15:0] ID_LAST     = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_STARTED,
        KIND_IMMEDIATE,
        KIND_FULL,
        KIND_UPDATE,
        KIND_ACK,
        KIND_IDLE
    } kind_t;

    typedef enum logic [2:0] {
        VS_ZERO,
        VS_IN_TO,
        VS_IN_FROM,
        VS_SLOT_TO,
        VS_INTERP
    } val_sel_t;

    typedef enum logic [1:0] {
        ID_NONE,
        ID_NEW,
        ID_SLOT
    } id_sel_t;

    typedef struct packed {
        logic     load;
        logic     rd;
        logic     idx_inc;
        logic     div_go;
        logic     div_tick;
        logic     u_ld;
        logic     ease_a;
        logic     ease_b;
        logic     ease_c;
        logic     mul;
        logic     clr_all;
        logic     clr_slot;
        logic     wr_slot;
        logic     wr_snap;
        logic     pend_set;
        kind_t    pend_kind;
        logic     pend_done;
        val_sel_t pend_val;
        id_sel_t  pend_id;
        logic     send;
        logic     send_last;
        logic     send_dflt;
        kind_t    dflt_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       respect;
        logic       scale;
        logic       motion;
        logic       eff_zero;
        logic       full;
        logic       slot_vld;
        logic       id_match;
        logic       slot_respect;
        logic       tdone;
        logic       idx_last;
        logic       div_busy;
        logic       pend_vld;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== sv/mcete_in_if.sv =====
// input channel: one command per transfer
interface mcete_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] now_time;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
    logic [31:0] length_us;
    logic [2:0]  curve;
    logic [1:0]  start_mode;
    logic [15:0] target_id;

    modport source (output valid, cmd, now_time, start_value, end_value, length_us, curve,
                    start_mode, target_id, input ready);
    modport sink (input valid, cmd, now_time, start_value, end_value, length_us, curve,
                  start_mode, target_id, output ready);
endinterface

// ===== sv/mcete_out_if.sv =====
// result channel: one result per transfer
interface mcete_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] entry_id;
    logic signed [31:0] value;
    logic        done_res;
    logic        last;

    modport source (output valid, kind, entry_id, value, done_res, last, input ready);
    modport sink (input valid, kind, entry_id, value, done_res, last, output ready);
endinterface

// ===== sv/mcete_div.sv =====
// restoring divider, one quotient bit per cycle
module mcete_div #(
    parameter int NW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go,
    input  logic [NW-1:0] dividend,
    input  logic [31:0]   divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [31:0]   dvs_reg;
    logic [32:0]   trial;
    logic [32:0]   diff;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

// ===== sv/mcete_dp.sv =====
// datapath: slot table, config registers, divider, easing and output stage
module mcete_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [2:0]          in_cmd,
    input  logic [31:0]         in_now,
    input  logic [31:0]         in_from,
    input  logic [31:0]         in_to,
    input  logic [31:0]         in_len,
    input  logic [2:0]          in_curve,
    input  logic [1:0]          in_mode,
    input  logic [15:0]         in_tid,
    input  mcete_pkg::dp_cmd_t  c,
    output mcete_pkg::dp_stat_t stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [2:0]          out_kind,
    output logic [15:0]         out_id,
    output logic [31:0]         out_value,
    output logic                out_done,
    output logic                out_last
);
    import mcete_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int W  = F + 3;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = (32 + F > 41) ? 32 + F : 41;
    localparam int PW = 33 + F + 2;
    localparam logic [W-1:0] ONE_W  = {{(W-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic [W-1:0] HALF_W = ONE_W >> 1;

    // config
    logic        motion_reg;
    logic [15:0] speed_reg;
    logic        reduced_reg;

    // latched item
    logic [2:0]  op_reg;
    logic [31:0] now_reg;
    logic [31:0] from_reg;
    logic [31:0] to_reg;
    logic [31:0] len_reg;
    logic [2:0]  curve_reg;
    logic [1:0]  mode_reg;
    logic [15:0] tid_reg;

    // table
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [19:0] rec_mem   [TABLE_DEPTH];
    logic [31:0] from_mem  [TABLE_DEPTH];
    logic [31:0] to_mem    [TABLE_DEPTH];
    logic [31:0] start_mem [TABLE_DEPTH];
    logic [31:0] dur_mem   [TABLE_DEPTH];
    logic [19:0] rec_rd_reg;
    logic [31:0] from_rd_reg;
    logic [31:0] to_rd_reg;
    logic [31:0] start_rd_reg;
    logic [31:0] dur_rd_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] free_idx;
    logic          any_free;
    logic [15:0]   id_reg;

    // arithmetic
    logic          respect;
    logic          scale;
    logic [15:0]   spd;
    logic          div_busy;
    logic [NW-1:0] quo;
    logic [NW-1:0] div_dividend;
    logic [31:0]   div_divisor;
    logic [31:0]   eff;
    logic [31:0]   from_eff;
    logic [31:0]   start_eff;
    logic [31:0]   elapsed;
    logic          tdone;
    logic [W-1:0]  u_reg;
    logic [W-1:0]  m1_reg;
    logic [W-1:0]  m2_reg;
    logic [F:0]    eased_reg;
    logic [W-1:0]  a1, b1, b2, r_ease, f3, f5;
    logic [2*W-1:0] pa, pb;
    logic          lt_half;
    logic [2:0]    crv;
    logic signed [32:0]   diff_s;
    logic signed [F+1:0]  eas_s;
    logic signed [PW-1:0] prod_full;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] from_ext;
    logic signed [PW-1:0] interp_sum;

    // pending result and output
    logic        pend_vld_reg;
    kind_t       pend_kind_reg;
    logic [15:0] pend_id_reg;
    logic [31:0] pend_val_reg;
    logic        pend_done_reg;
    logic [31:0] val_sel;
    logic [15:0] id_sel;
    logic        ov_reg;
    logic [2:0]  ok_reg;
    logic [15:0] oi_reg;
    logic [31:0] ox_reg;
    logic        od_reg;
    logic        ol_reg;
    logic        out_free;

    assign respect = (mode_reg == MODE_SCALED) || (mode_reg == MODE_UNSCALED);
    assign scale   = (mode_reg == MODE_SCALED);
    assign spd     = (speed_reg == 16'd0) ? 16'd1 : speed_reg;

    always_comb
    begin
        free_idx = '0;
        any_free = 1'b0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
                any_free = 1'b1;
            end
        end
    end

    assign elapsed = now_reg - start_rd_reg;
    assign tdone   = (dur_rd_reg == 32'd0) || (elapsed >= dur_rd_reg);

    assign div_dividend = c.div_tick ? NW'({elapsed, {F{1'b0}}})
                                     : NW'({len_reg, 8'd0}) + NW'(spd - 16'd1);
    assign div_divisor  = c.div_tick ? dur_rd_reg : {16'd0, spd};

    mcete_div #(.NW(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (c.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_comb
    begin
        if (respect && reduced_reg)
        begin
            eff = SNAP_US;
        end
        else if (scale)
        begin
            eff = (|quo[NW-1:32]) ? 32'hFFFF_FFFF : quo[31:0];
        end
        else
        begin
            eff = len_reg;
        end
    end
    assign from_eff  = (respect && reduced_reg) ? to_reg : from_reg;
    assign start_eff = (respect && reduced_reg) ? now_reg - SNAP_US : now_reg;

    // easing
    assign crv     = rec_rd_reg[18:16];
    assign lt_half = u_reg < HALF_W;
    assign f3      = ONE_W - u_reg;
    assign f5      = (ONE_W << 1) - (u_reg << 1);

    always_comb
    begin
        a1 = u_reg;
        b1 = ONE_W;
        b2 = ONE_W;
        case (crv)
            CURVE_OUT_QUAD:
            begin
                b1 = (ONE_W << 1) - u_reg;
            end
            CURVE_INOUT_QUAD:
            begin
                if (lt_half)
                begin
                    b1 = u_reg;
                end
                else
                begin
                    a1 = (ONE_W << 2) - (u_reg << 1);
                    b1 = u_reg;
                end
            end
            CURVE_OUT_CUBIC:
            begin
                a1 = f3;
                b1 = f3;
                b2 = f3;
            end
            CURVE_IN_CUBIC:
            begin
                b1 = u_reg;
                b2 = u_reg;
            end
            CURVE_INOUT_CUBIC:
            begin
                if (lt_half)
                begin
                    b1 = u_reg;
                    b2 = u_reg;
                end
                else
                begin
                    a1 = f5;
                    b1 = f5;
                    b2 = f5;
                end
            end
            default:
            begin
                b1 = ONE_W;
            end
        endcase
    end

    assign pa = a1 * b1;
    assign pb = m1_reg * b2;

    always_comb
    begin
        case (crv)
            CURVE_OUT_QUAD:    r_ease = m1_reg;
            CURVE_INOUT_QUAD:
            begin
                if (lt_half)
                begin
                    r_ease = m1_reg << 1;
                end
                else
                begin
                    r_ease = (m1_reg > ONE_W) ? m1_reg - ONE_W : '0;
                end
            end
            CURVE_OUT_CUBIC:   r_ease = ONE_W - m2_reg;
            CURVE_IN_CUBIC:    r_ease = m2_reg;
            CURVE_INOUT_CUBIC: r_ease = lt_half ? (m2_reg << 2) : ONE_W - (m2_reg >> 1);
            default:           r_ease = u_reg;
        endcase
    end

    assign diff_s     = $signed({to_rd_reg[31], to_rd_reg}) -
                        $signed({from_rd_reg[31], from_rd_reg});
    assign eas_s      = $signed({1'b0, eased_reg});
    assign prod_full  = diff_s * eas_s;
    assign from_ext   = PW'($signed(from_rd_reg));
    assign interp_sum = from_ext + (prod_reg >>> F);

    always_ff @(posedge clk)
    begin
        if (c.u_ld)
        begin
            u_reg <= tdone ? ONE_W : {2'b00, quo[F:0]};
        end
        if (c.ease_a)
        begin
            m1_reg <= pa[F +: W];
        end
        if (c.ease_b)
        begin
            m2_reg <= pb[F +: W];
        end
        if (c.ease_c)
        begin
            eased_reg <= (r_ease > ONE_W) ? ONE_W[F:0] : r_ease[F:0];
        end
        if (c.mul)
        begin
            prod_reg <= prod_full;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg  <= 1'b1;
            speed_reg   <= SPEED_RESET;
            reduced_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOTION:  motion_reg  <= cfg_data[0];
                CFG_SPEED:   speed_reg   <= cfg_data;
                CFG_REDUCED: reduced_reg <= cfg_data[0];
                default:     motion_reg  <= motion_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (c.load)
        begin
            op_reg    <= in_cmd;
            now_reg   <= in_now;
            from_reg  <= in_from;
            to_reg    <= in_to;
            len_reg   <= in_len;
            curve_reg <= in_curve;
            mode_reg  <= in_mode;
            tid_reg   <= in_tid;
        end
    end

    // slot table
    always_comb
    begin
        valid_next = valid_reg;
        if (c.clr_all)
        begin
            valid_next = '0;
        end
        if (c.clr_slot)
        begin
            valid_next[idx_reg] = 1'b0;
        end
        if (c.wr_slot)
        begin
            valid_next[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            idx_reg   <= '0;
            id_reg    <= ID_FIRST;
        end
        else
        begin
            valid_reg <= valid_next;
            if (c.load)
            begin
                idx_reg <= '0;
            end
            else if (c.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (c.wr_slot)
            begin
                id_reg <= (id_reg == ID_LAST) ? ID_FIRST : id_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c.wr_slot)
        begin
            rec_mem[free_idx]   <= {respect, curve_reg, id_reg};
            from_mem[free_idx]  <= from_eff;
            to_mem[free_idx]    <= to_reg;
            start_mem[free_idx] <= start_eff;
            dur_mem[free_idx]   <= eff;
        end
        else if (c.wr_snap)
        begin
            from_mem[idx_reg]  <= to_rd_reg;
            start_mem[idx_reg] <= now_reg - SNAP_US;
            dur_mem[idx_reg]   <= SNAP_US;
        end
        if (c.rd)
        begin
            rec_rd_reg   <= rec_mem[idx_reg];
            from_rd_reg  <= from_mem[idx_reg];
            to_rd_reg    <= to_mem[idx_reg];
            start_rd_reg <= start_mem[idx_reg];
            dur_rd_reg   <= dur_mem[idx_reg];
        end
    end

    // pending result and output register
    always_comb
    begin
        case (c.pend_val)
            VS_IN_TO:   val_sel = to_reg;
            VS_IN_FROM: val_sel = from_eff;
            VS_SLOT_TO: val_sel = to_rd_reg;
            VS_INTERP:  val_sel = interp_sum[31:0];
            default:    val_sel = 32'd0;
        endcase
        case (c.pend_id)
            ID_NEW:  id_sel = id_reg;
            ID_SLOT: id_sel = rec_rd_reg[15:0];
            default: id_sel = 16'd0;
        endcase
    end

    assign out_free = !ov_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (c.pend_set)
            begin
                pend_vld_reg <= 1'b1;
            end
            else if (c.send)
            begin
                pend_vld_reg <= 1'b0;
            end
            if (c.send || c.send_dflt)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (c.pend_set)
        begin
            pend_kind_reg <= c.pend_kind;
            pend_id_reg   <= id_sel;
            pend_val_reg  <= val_sel;
            pend_done_reg <= c.pend_done;
        end
        if (c.send)
        begin
            ok_reg <= pend_kind_reg;
            oi_reg <= pend_id_reg;
            ox_reg <= pend_val_reg;
            od_reg <= pend_done_reg;
            ol_reg <= c.send_last;
        end
        else if (c.send_dflt)
        begin
            ok_reg <= c.dflt_kind;
            oi_reg <= 16'd0;
            ox_reg <= 32'd0;
            od_reg <= 1'b0;
            ol_reg <= 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = ok_reg;
    assign out_id    = oi_reg;
    assign out_value = ox_reg;
    assign out_done  = od_reg;
    assign out_last  = ol_reg;

    assign stat.op           = op_reg;
    assign stat.respect      = respect;
    assign stat.scale        = scale;
    assign stat.motion       = motion_reg;
    assign stat.eff_zero     = (eff == 32'd0);
    assign stat.full         = !any_free;
    assign stat.slot_vld     = valid_reg[idx_reg];
    assign stat.id_match     = (rec_rd_reg[15:0] == tid_reg);
    assign stat.slot_respect = rec_rd_reg[19];
    assign stat.tdone        = tdone;
    assign stat.idx_last     = (idx_reg == IW'(TABLE_DEPTH - 1));
    assign stat.div_busy     = div_busy;
    assign stat.pend_vld     = pend_vld_reg;
    assign stat.out_free     = out_free;
endmodule

// ===== sv/mcete_ctrl.sv =====
// command sequencer: start and cancel-all, plus cancel-by-id, snap and tick walks over the table
module mcete_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mcete_pkg::dp_stat_t stat,
    output mcete_pkg::dp_cmd_t  c
);
    import mcete_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SDIV,
        ST_SEFF,
        ST_RD,
        ST_EV,
        ST_TDIV,
        ST_TU,
        ST_EA,
        ST_EB,
        ST_EC,
        ST_MUL,
        ST_PUSH,
        ST_FINAL
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next;

    always_comb
    begin
        c          = '0;
        state_next = state_reg;
        n_next     = n_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    c.load     = 1'b1;
                    n_next     = '0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.op)
                    OP_START:
                    begin
                        if (stat.respect && !stat.motion)
                        begin
                            c.pend_set  = 1'b1;
                            c.pend_kind = KIND_IMMEDIATE;
                            c.pend_val  = VS_IN_TO;
                            c.pend_done = 1'b1;
                            state_next  = ST_FINAL;
                        end
                        else if (stat.scale)
                        begin
                            c.div_go   = 1'b1;
                            state_next = ST_SDIV;
                        end
                        else
                        begin
                            state_next = ST_SEFF;
                        end
                    end
                    OP_CANCEL_ID, OP_SNAP, OP_TICK: state_next = ST_RD;
                    OP_CANCEL_ALL:
                    begin
                        c.clr_all  = 1'b1;
                        state_next = ST_FINAL;
                    end
                    default: state_next = ST_FINAL;
                endcase
            end
            ST_SDIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_SEFF;
                end
            end
            ST_SEFF:
            begin
                c.pend_set = 1'b1;
                if (stat.eff_zero)
                begin
                    c.pend_kind = KIND_IMMEDIATE;
                    c.pend_val  = VS_IN_TO;
                    c.pend_done = 1'b1;
                end
                else if (stat.full)
                begin
                    c.pend_kind = KIND_FULL;
                end
                else
                begin
                    c.wr_slot   = 1'b1;
                    c.pend_kind = KIND_STARTED;
                    c.pend_val  = VS_IN_FROM;
                    c.pend_id   = ID_NEW;
                end
                state_next = ST_FINAL;
            end
            ST_RD:
            begin
                if (stat.op == OP_TICK && n_reg == CNT_W'(MAX_RESULTS))
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    c.rd       = 1'b1;
                    state_next = ST_EV;
                end
            end
            ST_EV:
            begin
                state_next = stat.idx_last ? ST_FINAL : ST_RD;
                c.idx_inc  = !stat.idx_last;
                if (stat.slot_vld)
                begin
                    if (stat.op == OP_CANCEL_ID)
                    begin
                        c.clr_slot = stat.id_match;
                    end
                    else if (stat.op == OP_SNAP)
                    begin
                        if (stat.slot_respect)
                        begin
                            if (n_reg != CNT_W'(MAX_RESULTS))
                            begin
                                c.idx_inc  = 1'b0;
                                state_next = ST_PUSH;
                            end
                            else
                            begin
                                c.wr_snap = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        c.idx_inc = 1'b0;
                        if (stat.tdone)
                        begin
                            state_next = ST_TU;
                        end
                        else
                        begin
                            c.div_go   = 1'b1;
                            c.div_tick = 1'b1;
                            state_next = ST_TDIV;
                        end
                    end
                end
            end
            ST_TDIV:
            begin
                c.div_tick = 1'b1;
                if (!stat.div_busy)
                begin
                    state_next = ST_TU;
                end
            end
            ST_TU:
            begin
                c.u_ld     = 1'b1;
                state_next = ST_EA;
            end
            ST_EA:
            begin
                c.ease_a   = 1'b1;
                state_next = ST_EB;
            end
            ST_EB:
            begin
                c.ease_b   = 1'b1;
                state_next = ST_EC;
            end
            ST_EC:
            begin
                c.ease_c   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                c.mul      = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!stat.pend_vld || stat.out_free)
                begin
                    c.send      = stat.pend_vld;
                    c.pend_set  = 1'b1;
                    c.pend_kind = KIND_UPDATE;
                    c.pend_id   = ID_SLOT;
                    if (stat.op == OP_SNAP)
                    begin
                        c.pend_val = VS_SLOT_TO;
                        c.wr_snap  = 1'b1;
                    end
                    else
                    begin
                        c.pend_val  = VS_INTERP;
                        c.pend_done = stat.tdone;
                        c.clr_slot  = stat.tdone;
                    end
                    n_next     = n_reg + 1'b1;
                    c.idx_inc  = !stat.idx_last;
                    state_next = stat.idx_last ? ST_FINAL : ST_RD;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    c.send      = stat.pend_vld;
                    c.send_last = 1'b1;
                    c.send_dflt = !stat.pend_vld;
                    c.dflt_kind = (stat.op == OP_TICK) ? KIND_IDLE : KIND_ACK;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
endmodule

// ===== sv/multi_channel_eased_tween_engine_top.sv =====
// tween engine top level: sequencer, datapath and assertions
// one command at a time; a scaled start with motion on also runs the divider
// cancel-by-id and snap walk every slot; a tick walks them until it has MAX_RESULTS results
// a live slot on a tick runs the divider unless it has reached its end, then ST_TU, ST_EA,
// ST_EB, ST_EC, ST_MUL and ST_PUSH; the divider is NW = max(41, 32+FRAC_BITS) bits wide
// reset clears slot valid bits, presets config registers and the id counter, no clearing pass
module multi_channel_eased_tween_engine_top #(
    parameter int TABLE_DEPTH = mcete_pkg::DEF_TABLE_DEPTH,
    parameter int FRAC_BITS   = mcete_pkg::DEF_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    mcete_in_if.sink    req,
    mcete_out_if.source rsp
);
    import mcete_pkg::*;
    `include "assert_macros.svh"

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mcete_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .c        (cmd)
    );

    mcete_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (req.cmd),
        .in_now    (req.now_time),
        .in_from   (req.start_value),
        .in_to     (req.end_value),
        .in_len    (req.length_us),
        .in_curve  (req.curve),
        .in_mode   (req.start_mode),
        .in_tid    (req.target_id),
        .c         (cmd),
        .stat      (stat),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_kind  (rsp.kind),
        .out_id    (rsp.entry_id),
        .out_value (rsp.value),
        .out_done  (rsp.done_res),
        .out_last  (rsp.last)
    );

    `CHK_NEXT(a_one_item, req.valid && req.ready, !req.ready, "second transfer while busy")
    `CHK_IMPLY(a_wr_free, cmd.wr_slot, !stat.full, "slot write with full table")
    `CHK_IMPLY(a_div_idle, cmd.div_go, !stat.div_busy, "divider restarted while busy")
    `CHK_IMPLY(a_send_free, cmd.send || cmd.send_dflt, stat.out_free, "output overrun")
endmodule

// ===== dv/tb_multi_channel_eased_tween_engine_top.sv =====
// self-checking testbench of the tween engine: directed and random commands against a predictor
module tb_multi_channel_eased_tween_engine_top;
    import mcete_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = DEF_TABLE_DEPTH;
    localparam int          FB          = DEF_FRAC_BITS;
    localparam longint      ONE         = 64'd1 << FB;
    localparam int          DRAIN_WAIT  = 1200;
    localparam int          STALL_LIMIT = 20000;
    localparam logic [2:0]  OP_SPARE_A  = 3'd5;
    localparam logic [2:0]  OP_SPARE_B  = 3'd7;
    localparam logic [2:0]  CURVE_SPARE_A = 3'd6;
    localparam logic [2:0]  CURVE_SPARE_B = 3'd7;
    localparam logic [1:0]  MODE_TIMER  = 2'd2;
    localparam logic [1:0]  MODE_SPARE  = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [31:0]        now_time;
        logic signed [31:0] start_value;
        logic signed [31:0] end_value;
        logic [31:0]        length_us;
        logic [2:0]         curve;
        logic [1:0]         start_mode;
        logic [15:0]        target_id;
    } tween_cmd_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [15:0]        entry_id;
        logic signed [31:0] value;
        logic               done_res;
        logic               last;
    } tween_res_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    mcete_in_if  req_if ();
    mcete_out_if rsp_if ();

    multi_channel_eased_tween_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // predictor state
    bit                 slot_live  [DEPTH];
    logic [15:0]        slot_id    [DEPTH];
    logic [2:0]         slot_curve [DEPTH];
    bit                 slot_resp  [DEPTH];
    logic signed [31:0] slot_from  [DEPTH];
    logic signed [31:0] slot_to    [DEPTH];
    logic [31:0]        slot_t0    [DEPTH];
    logic [31:0]        slot_dur   [DEPTH];
    logic [15:0]        id_next;
    bit                 m_motion;
    logic [15:0]        m_speed;
    bit                 m_reduced;

    tween_res_t  pending_results[$];
    int          errors;
    int          tx_idle;
    int          rx_idle;
    int          rx_hold;
    int          stall_cnt;
    int          n_sent;
    int          n_checked;
    logic [31:0] now_us;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint unsigned fx(longint unsigned a, longint unsigned b);
        return (a * b) >> FB;
    endfunction

    function automatic longint unsigned eased(logic [2:0] c, longint unsigned t);
        longint unsigned half;
        longint unsigned f;
        longint unsigned r;
        half = ONE >> 1;
        case (c)
            CURVE_OUT_QUAD: r = fx(t, 2 * ONE - t);
            CURVE_INOUT_QUAD:
            begin
                if (t < half)
                begin
                    r = 2 * fx(t, t);
                end
                else
                begin
                    r = fx(4 * ONE - 2 * t, t);
                    r = (r > ONE) ? r - ONE : 0;
                end
            end
            CURVE_OUT_CUBIC:
            begin
                f = ONE - t;
                r = ONE - fx(fx(f, f), f);
            end
            CURVE_IN_CUBIC: r = fx(fx(t, t), t);
            CURVE_INOUT_CUBIC:
            begin
                if (t < half)
                begin
                    r = 4 * fx(fx(t, t), t);
                end
                else
                begin
                    f = 2 * ONE - 2 * t;
                    r = ONE - (fx(fx(f, f), f) >> 1);
                end
            end
            default: r = t;
        endcase
        return (r > ONE) ? ONE : r;
    endfunction

    function automatic tween_res_t mk_res(kind_t k, logic [15:0] id, logic [31:0] v, logic d);
        tween_res_t r;
        r.kind     = k;
        r.entry_id = id;
        r.value    = v;
        r.done_res = d;
        r.last     = 1'b0;
        return r;
    endfunction

    task automatic predict_results(input tween_cmd_t c);
        tween_res_t         res[$];
        tween_res_t         tail;
        bit                 respect;
        longint unsigned    eff;
        longint unsigned    sc;
        longint unsigned    u;
        longint             prod;
        logic signed [31:0] from_v;
        logic [31:0]        t0;
        logic [31:0]        el;
        bit                 done;
        int                 slot;
        respect = (c.start_mode == MODE_SCALED) || (c.start_mode == MODE_UNSCALED);
        case (c.cmd)
            OP_START:
            begin
                from_v = c.start_value;
                t0 = c.now_time;
                eff = c.length_us;
                if (c.start_mode == MODE_SCALED)
                begin
                    sc = (m_speed == 0) ? 1 : m_speed;
                    eff = (eff * 256 + sc - 1) / sc;
                    if (eff > 64'hFFFF_FFFF)
                        eff = 64'hFFFF_FFFF;
                end
                if (respect && m_reduced)
                begin
                    eff = SNAP_US;
                    from_v = c.end_value;
                    t0 = c.now_time - SNAP_US;
                end
                slot = -1;
                for (int i = DEPTH - 1; i >= 0; i--)
                    if (!slot_live[i])
                        slot = i;
                if ((respect && !m_motion) || eff == 0)
                    res = {res, mk_res(KIND_IMMEDIATE, 16'd0, c.end_value, 1'b1)};
                else if (slot < 0)
                    res = {res, mk_res(KIND_FULL, 16'd0, 32'd0, 1'b0)};
                else
                begin
                    slot_live[slot]  = 1'b1;
                    slot_id[slot]    = id_next;
                    slot_curve[slot] = c.curve;
                    slot_resp[slot]  = respect;
                    slot_from[slot]  = from_v;
                    slot_to[slot]    = c.end_value;
                    slot_t0[slot]    = t0;
                    slot_dur[slot]   = eff[31:0];
                    res = {res, mk_res(KIND_STARTED, id_next, from_v, 1'b0)};
                    id_next = (id_next == ID_LAST) ? ID_FIRST : id_next + 16'd1;
                end
            end
            OP_CANCEL_ID:
            begin
                if (c.target_id != 0)
                    for (int i = 0; i < DEPTH; i++)
                        if (slot_live[i] && slot_id[i] == c.target_id)
                            slot_live[i] = 1'b0;
                res = {res, mk_res(KIND_ACK, 16'd0, 32'd0, 1'b0)};
            end
            OP_CANCEL_ALL:
            begin
                for (int i = 0; i < DEPTH; i++)
                    slot_live[i] = 1'b0;
                res = {res, mk_res(KIND_ACK, 16'd0, 32'd0, 1'b0)};
            end
            OP_SNAP:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (slot_live[i] && slot_resp[i])
                    begin
                        slot_from[i] = slot_to[i];
                        slot_t0[i]   = c.now_time - SNAP_US;
                        slot_dur[i]  = SNAP_US;
                        if (res.size() < MAX_RESULTS)
                            res = {res, mk_res(KIND_UPDATE, slot_id[i], slot_to[i], 1'b0)};
                    end
                end
                if (res.size() == 0)
                    res = {res, mk_res(KIND_ACK, 16'd0, 32'd0, 1'b0)};
            end
            OP_TICK:
            begin
                for (int i = 0; i < DEPTH && res.size() < MAX_RESULTS; i++)
                begin
                    if (slot_live[i])
                    begin
                        el = c.now_time - slot_t0[i];
                        done = (slot_dur[i] == 0) || (el >= slot_dur[i]);
                        u = done ? ONE : ((longint'(el) << FB) / slot_dur[i]);
                        prod = (longint'(slot_to[i]) - longint'(slot_from[i]))
                               * longint'(eased(slot_curve[i], u));
                        res = {res, mk_res(KIND_UPDATE, slot_id[i],
                                           slot_from[i] + 32'(prod >>> FB), done)};
                        if (done)
                            slot_live[i] = 1'b0;
                    end
                end
                if (res.size() == 0)
                    res = {res, mk_res(KIND_IDLE, 16'd0, 32'd0, 1'b0)};
            end
            default: res = {res, mk_res(KIND_ACK, 16'd0, 32'd0, 1'b0)};
        endcase
        tail = res.pop_back();
        tail.last = 1'b1;
        res = {res, tail};
        pending_results = {pending_results, res};
    endtask

    // one transfer on the command channel, entered and left at a falling edge
    task automatic send_cmd(input tween_cmd_t c);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.cmd         = c.cmd;
        req_if.now_time    = c.now_time;
        req_if.start_value = c.start_value;
        req_if.end_value   = c.end_value;
        req_if.length_us   = c.length_us;
        req_if.curve       = c.curve;
        req_if.start_mode  = c.start_mode;
        req_if.target_id   = c.target_id;
        req_if.valid       = 1'b1;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_results(c);
        n_sent++;
        @(negedge clk);
    endtask

    function automatic tween_cmd_t mk_cmd(logic [2:0] op, logic [31:0] t);
        tween_cmd_t c;
        c = '0;
        c.cmd = op;
        c.now_time = t;
        c.target_id = 16'($urandom);
        return c;
    endfunction

    task automatic send_start(input logic [31:0] t, input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] len, input logic [2:0] cv,
                              input logic [1:0] md);
        tween_cmd_t c;
        c = mk_cmd(OP_START, t);
        c.start_value = a;
        c.end_value   = b;
        c.length_us   = len;
        c.curve       = cv;
        c.start_mode  = md;
        send_cmd(c);
    endtask

    task automatic send_simple(input logic [2:0] op, input logic [31:0] t,
                               input logic [15:0] tid);
        tween_cmd_t c;
        c = mk_cmd(op, t);
        c.target_id = tid;
        send_cmd(c);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT / 8)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MOTION:  m_motion = data[0];
            CFG_SPEED:   m_speed = data;
            CFG_REDUCED: m_reduced = data[0];
            default: ;
        endcase
    endtask

    task automatic test_basic_curves();
        send_simple(OP_TICK, 32'd0, 16'd0);
        for (int cv = 0; cv < 8; cv++)
            send_start(32'd100, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1000, cv[2:0],
                       (cv < 4) ? cv[1:0] : MODE_SCALED);
        send_start(32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, CURVE_LINEAR, MODE_TIMER);
        send_simple(OP_TICK, 32'd350, 16'd0);
        send_simple(OP_TICK, 32'd600, 16'd0);
        send_simple(OP_CANCEL_ID, 32'd0, 16'd0);
        send_simple(OP_CANCEL_ID, 32'd0, 16'd3);
        send_simple(OP_SNAP, 32'd700, 16'd0);
        send_simple(OP_TICK, 32'd650, 16'd0);
        send_simple(OP_SPARE_A, 32'd0, 16'hFFFF);
        send_simple(OP_SPARE_B, 32'hFFFF_FFFF, 16'd1);
        send_simple(OP_TICK, 32'd2000, 16'd0);
        send_simple(OP_SNAP, 32'd2000, 16'd0);
        send_simple(OP_CANCEL_ALL, 32'd0, 16'd0);
    endtask

    task automatic test_motion_settings();
        write_reg(CFG_MOTION, 16'd0);
        send_start(32'd10, 32'd5, 32'hFFFF_0000, 32'd500, CURVE_LINEAR, MODE_SCALED);
        send_start(32'd10, 32'd5, 32'hFFFF_0000, 32'd500, CURVE_LINEAR, MODE_TIMER);
        write_reg(CFG_MOTION, 16'd1);
        write_reg(CFG_REDUCED, 16'd1);
        send_start(32'd10, 32'd5, 32'd77, 32'd500, CURVE_OUT_CUBIC, MODE_UNSCALED);
        send_start(32'd10, 32'd5, 32'd77, 32'd500, CURVE_OUT_CUBIC, MODE_SPARE);
        send_simple(OP_TICK, 32'd10, 16'd0);
        write_reg(CFG_REDUCED, 16'd0);
        write_reg(CFG_SPEED, 16'd1);
        send_start(32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, CURVE_LINEAR, MODE_SCALED);
        write_reg(CFG_SPEED, 16'hFFFF);
        send_start(32'd0, 32'd0, 32'd1, 32'd1, CURVE_LINEAR, MODE_SCALED);
        send_start(32'd0, 32'd0, 32'd1, 32'd0, CURVE_LINEAR, MODE_SCALED);
        write_reg(CFG_SPEED, 16'd0);
        send_start(32'd0, 32'd9, 32'd1, 32'd3, CURVE_IN_CUBIC, MODE_SCALED);
        send_simple(OP_TICK, 32'hFFFF_FFF0, 16'd0);
        send_simple(OP_CANCEL_ALL, 32'd0, 16'd0);
        write_reg(CFG_SPEED, SPEED_RESET);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < DEPTH + 2; i++)
            send_start(32'd0, $urandom, $urandom, 32'd1_000_000, i[2:0], MODE_TIMER);
        send_simple(OP_SNAP, 32'd0, 16'd0);
        send_simple(OP_TICK, 32'd100, 16'd0);
        send_simple(OP_CANCEL_ALL, 32'd0, 16'd0);
    endtask

    task automatic test_backpressure();
        wait_drained();
        rx_hold = 400;
        for (int i = 0; i < 12; i++)
            send_start(now_us, $urandom, $urandom, 32'd3000, i[2:0], MODE_UNSCALED);
        send_simple(OP_TICK, now_us + 32'd1500, 16'd0);
        send_simple(OP_SNAP, now_us + 32'd1600, 16'd0);
        wait_drained();
        send_simple(OP_TICK, now_us + 32'd5000, 16'd0);
        send_simple(OP_CANCEL_ALL, 32'd0, 16'd0);
    endtask

    task automatic test_random(input int n, input int tx_pct, input int rx_pct);
        tween_cmd_t c;
        int         r;
        tx_idle = tx_pct;
        rx_idle = rx_pct;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            now_us = now_us + $urandom_range(0, 600);
            c = mk_cmd(OP_TICK, now_us);
            c.start_value = $urandom;
            c.end_value   = $urandom;
            if (r < 42)
            begin
                c.cmd = OP_START;
                c.curve = 3'($urandom_range(0, 7));
                c.start_mode = 2'($urandom_range(0, 3));
                r = $urandom_range(0, 9);
                c.length_us = (r == 0) ? 32'd0 : (r == 1) ? $urandom : $urandom_range(1, 20000);
            end
            else if (r < 78)
            begin
                now_us = now_us + $urandom_range(0, 6000);
                if ($urandom_range(0, 29) == 0)
                    now_us = $urandom;
                c.now_time = now_us;
            end
            else if (r < 88)
            begin
                c.cmd = OP_CANCEL_ID;
                if ($urandom_range(0, 3) != 0)
                    c.target_id = id_next - 16'($urandom_range(1, 16));
            end
            else if (r < 93)
                c.cmd = OP_SNAP;
            else if (r < 96)
                c.cmd = OP_CANCEL_ALL;
            else
                c.cmd = 3'($urandom_range(5, 7));
            send_cmd(c);
        end
    endtask

    // result checking and stall watchdog
    always @(posedge clk)
    begin
        tween_res_t e;
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                n_checked++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result kind=%0d id=%0d value=%0h", $realtime,
                             rsp_if.kind, rsp_if.entry_id, rsp_if.value);
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (e.kind !== rsp_if.kind || e.entry_id !== rsp_if.entry_id ||
                        e.value !== rsp_if.value || e.done_res !== rsp_if.done_res ||
                        e.last !== rsp_if.last)
                    begin
                        errors++;
                        $display("%0t: expected kind=%0d id=%0d value=%0h done=%0b last=%0b",
                                 $realtime, e.kind, e.entry_id, e.value, e.done_res, e.last);
                        $display("%0t:   actual kind=%0d id=%0d value=%0h done=%0b last=%0b",
                                 $realtime, rsp_if.kind, rsp_if.entry_id, rsp_if.value,
                                 rsp_if.done_res, rsp_if.last);
                    end
                end
            end
        end
    end

    // result channel ready
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rsp_if.ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle);
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MOTION;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.cmd = OP_TICK;
        req_if.now_time = '0;
        req_if.start_value = '0;
        req_if.end_value = '0;
        req_if.length_us = '0;
        req_if.curve = CURVE_LINEAR;
        req_if.start_mode = MODE_SCALED;
        req_if.target_id = '0;
        rsp_if.ready = 1'b0;
        errors = 0;
        rx_hold = 0;
        stall_cnt = 0;
        n_sent = 0;
        n_checked = 0;
        now_us = '0;
        tx_idle = 31;
        rx_idle = 86;
        id_next = ID_FIRST;
        m_motion = 1'b1;
        m_speed = SPEED_RESET;
        m_reduced = 1'b0;
        foreach (slot_live[i])
            slot_live[i] = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_curves();
        test_motion_settings();
        test_table_full();
        test_backpressure();
        test_random(90, 31, 86);
        write_reg(CFG_SPEED, 16'd64);
        test_random(90, 86, 31);
        write_reg(CFG_REDUCED, 16'd1);
        test_random(20, 0, 0);
        write_reg(CFG_REDUCED, 16'd0);
        write_reg(CFG_SPEED, 16'd1024);
        test_random(60, 0, 0);

        wait_drained();
        repeat (DRAIN_WAIT)
            @(negedge clk);
        $display("sent %0d commands, checked %0d results: curves, modes, settings,", n_sent,
                 n_checked);
        $display("full table, cancel, snap, stalls and random traffic");
        if (errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== multi_channel_eased_tween_engine_top.f =====
+incdir+sv
sv/mcete_pkg.sv
sv/mcete_in_if.sv
sv/mcete_out_if.sv
sv/mcete_div.sv
sv/mcete_dp.sv
sv/mcete_ctrl.sv
sv/multi_channel_eased_tween_engine_top.sv
dv/tb_multi_channel_eased_tween_engine_top.sv
